### rtl/core/bsr_pkg.sv
// Shared types, constants and helpers for the BMP byte stream to RGB565 converter.
package bsr_pkg;

  // Geometry and field widths
  localparam int unsigned MAX_DIM   = 2048;
  localparam int unsigned DIM_W     = 12;
  localparam int unsigned ORIGIN_W  = 11;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIX_W     = 16;

  // Header layout: position of the last byte of each field
  localparam logic [15:0]        BMP_MAGIC      = 16'h4D42;
  localparam logic [COUNT_W-1:0] HEADER_BYTES   = 32'd34;
  localparam logic [COUNT_W-1:0] POS_MAGIC_END  = 32'd1;
  localparam logic [COUNT_W-1:0] POS_OFFSET_END = 32'd13;
  localparam logic [COUNT_W-1:0] POS_WIDTH_END  = 32'd21;
  localparam logic [COUNT_W-1:0] POS_HEIGHT_END = 32'd25;
  localparam logic [COUNT_W-1:0] POS_PLANES_END = 32'd27;
  localparam logic [COUNT_W-1:0] POS_COMP_END   = 32'd33;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_ERROR = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ERR_MAGIC    = 3'd0,
    ERR_PLANES   = 3'd1,
    ERR_COMPRESS = 3'd2,
    ERR_SIZE     = 3'd3,
    ERR_OFFSET   = 3'd4
  } err_t;

  typedef struct packed {
    kind_t             kind;
    logic [PIX_W-1:0]  pixel_565;
    logic [DIM_W-1:0]  screen_x;
    logic [DIM_W-1:0]  screen_y;
    err_t              error_code;
    logic              last_pixel;
  } result_t;

  // Keep a dimension only when it lies in 1..MAX_DIM, else zero
  function automatic logic [DIM_W-1:0] dim_checked(input logic [COUNT_W-1:0] v);
    logic ok;
    ok = (v >= COUNT_W'(1)) && (v <= COUNT_W'(MAX_DIM));
    return ok ? v[DIM_W-1:0] : '0;
  endfunction

endpackage

### rtl/core/bmp_stream_to_rgb565_top.sv
// Top level: BMP byte stream in, RGB565 pixel or header error beats out.
// The held byte steps the parser and any result goes to the result register
// when that slot is free; one byte per cycle while out_stall is low.
// The input register and result register each hold one beat; the parse state
// advances once per byte. Synchronous active-low reset clears the parse state,
// both origin registers and both valid bits; no clearing pass is needed.
module bmp_stream_to_rgb565_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte_value,
  input  logic                              in_file_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_result_kind,
  output logic [15:0]                       out_pixel_565,
  output logic [11:0]                       out_screen_x,
  output logic [11:0]                       out_screen_y,
  output logic [2:0]                        out_error_code,
  output logic                              out_last_pixel,
  input  logic                              cfg_we,
  input  logic [bsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsr_pkg::ORIGIN_W-1:0]      cfg_data
);

  logic [bsr_pkg::ORIGIN_W-1:0] origin_x_r, origin_y_r;
  logic                         byte_vld, file_start, free, advance, res_vld;
  logic [7:0]                   byte_value;
  bsr_pkg::result_t             res, out_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsr_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        bsr_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Move the held byte forward when the result slot is free
  assign advance = byte_vld && free;

  bsr_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_value (in_byte_value),
    .in_file_start (in_file_start),
    .advance       (advance),
    .byte_vld      (byte_vld),
    .byte_value    (byte_value),
    .file_start    (file_start)
  );

  bsr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .byte_value (byte_value),
    .file_start (file_start),
    .origin_x   (origin_x_r),
    .origin_y   (origin_y_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  bsr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_vld   (res_vld),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result beat onto the ports
  assign out_result_kind = out_res.kind;
  assign out_pixel_565   = out_res.pixel_565;
  assign out_screen_x    = out_res.screen_x;
  assign out_screen_y    = out_res.screen_y;
  assign out_error_code  = out_res.error_code;
  assign out_last_pixel  = out_res.last_pixel;

endmodule

### rtl/core/bsr_in_stage.sv
// Input register: captures one byte beat and holds it until the parser takes it.
module bsr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_file_start,
  input  logic       advance,
  output logic       byte_vld,
  output logic [7:0] byte_value,
  output logic       file_start
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       start_r;

  // Stall only while a held beat cannot move on
  assign in_stall   = vld_r && !advance;
  assign byte_vld   = vld_r;
  assign byte_value = byte_r;
  assign file_start = start_r;

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // Payload: load on an accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r  <= in_byte_value;
      start_r <= in_file_start;
    end
  end

endmodule

### rtl/core/bsr_parser.sv
// Header parser, offset skipper and pixel packer with its parse state registers.
module bsr_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    byte_value,
  input  logic                          file_start,
  input  logic [bsr_pkg::ORIGIN_W-1:0]  origin_x,
  input  logic [bsr_pkg::ORIGIN_W-1:0]  origin_y,
  output logic                          res_vld,
  output bsr_pkg::result_t              res
);

  bsr_pkg::phase_t                   phase_r, phase_nxt;
  logic [bsr_pkg::COUNT_W-1:0]       cnt_r, cnt_nxt;
  logic [bsr_pkg::COUNT_W-1:0]       shift_r, shift_nxt;
  logic [bsr_pkg::COUNT_W-1:0]       off_r, off_nxt;
  logic [bsr_pkg::DIM_W-1:0]         wid_r, wid_nxt;
  logic [bsr_pkg::DIM_W-1:0]         hgt_r, hgt_nxt;
  logic [7:0]                        blue_r, blue_nxt;
  logic [7:0]                        green_r, green_nxt;
  logic [1:0]                        bip_r, bip_nxt;
  logic [bsr_pkg::DIM_W-1:0]         col_r, col_nxt;
  logic [bsr_pkg::DIM_W-1:0]         row_r, row_nxt;

  // Current state, with a file start restarting everything
  bsr_pkg::phase_t                   ph_c;
  logic [bsr_pkg::COUNT_W-1:0]       cnt_c, shift_c, off_c, shift_new, cnt_inc;
  logic [bsr_pkg::DIM_W-1:0]         wid_c, hgt_c, col_c, row_c;
  logic [7:0]                        blue_c, green_c;
  logic [1:0]                        bip_c;
  logic [bsr_pkg::DIM_W:0]           col_inc, row_inc;
  logic                              last_col, last_img;

  always_comb begin
    ph_c    = file_start ? bsr_pkg::PH_HEADER : phase_r;
    cnt_c   = file_start ? '0 : cnt_r;
    shift_c = file_start ? '0 : shift_r;
    off_c   = file_start ? '0 : off_r;
    wid_c   = file_start ? '0 : wid_r;
    hgt_c   = file_start ? '0 : hgt_r;
    blue_c  = file_start ? '0 : blue_r;
    green_c = file_start ? '0 : green_r;
    bip_c   = file_start ? '0 : bip_r;
    col_c   = file_start ? '0 : col_r;
    row_c   = file_start ? '0 : row_r;
  end

  assign shift_new = {byte_value, shift_c[bsr_pkg::COUNT_W-1:8]};
  assign cnt_inc   = cnt_c + bsr_pkg::COUNT_W'(1);
  assign col_inc   = {1'b0, col_c} + (bsr_pkg::DIM_W+1)'(1);
  assign row_inc   = {1'b0, row_c} + (bsr_pkg::DIM_W+1)'(1);
  assign last_col  = col_inc >= {1'b0, wid_c};
  assign last_img  = last_col && (row_inc >= {1'b0, hgt_c});

  // Next state and result for the byte in hand
  always_comb begin
    phase_nxt = ph_c;
    cnt_nxt   = cnt_c;
    shift_nxt = shift_c;
    off_nxt   = off_c;
    wid_nxt   = wid_c;
    hgt_nxt   = hgt_c;
    blue_nxt  = blue_c;
    green_nxt = green_c;
    bip_nxt   = bip_c;
    col_nxt   = col_c;
    row_nxt   = row_c;
    res_vld   = 1'b0;
    res       = '0;

    unique case (ph_c)
      bsr_pkg::PH_HEADER: begin
        shift_nxt = shift_new;
        cnt_nxt   = cnt_inc;
        if (cnt_c == bsr_pkg::POS_MAGIC_END) begin
          if (shift_new[31:16] != bsr_pkg::BMP_MAGIC) begin
            res_vld        = 1'b1;
            res.kind       = bsr_pkg::KIND_ERROR;
            res.error_code = bsr_pkg::ERR_MAGIC;
            phase_nxt      = bsr_pkg::PH_IDLE;
          end
        end else if (cnt_c == bsr_pkg::POS_OFFSET_END) begin
          off_nxt = shift_new;
        end else if (cnt_c == bsr_pkg::POS_WIDTH_END) begin
          wid_nxt = bsr_pkg::dim_checked(shift_new);
        end else if (cnt_c == bsr_pkg::POS_HEIGHT_END) begin
          hgt_nxt = bsr_pkg::dim_checked(shift_new);
        end else if (cnt_c == bsr_pkg::POS_PLANES_END) begin
          if (shift_new[31:16] != 16'd1) begin
            res_vld        = 1'b1;
            res.kind       = bsr_pkg::KIND_ERROR;
            res.error_code = bsr_pkg::ERR_PLANES;
            phase_nxt      = bsr_pkg::PH_IDLE;
          end
        end else if (cnt_c == bsr_pkg::POS_COMP_END) begin
          // Compression, then size, then offset
          if (shift_new != '0) begin
            res_vld        = 1'b1;
            res.kind       = bsr_pkg::KIND_ERROR;
            res.error_code = bsr_pkg::ERR_COMPRESS;
            phase_nxt      = bsr_pkg::PH_IDLE;
          end else if (wid_c == '0 || hgt_c == '0) begin
            res_vld        = 1'b1;
            res.kind       = bsr_pkg::KIND_ERROR;
            res.error_code = bsr_pkg::ERR_SIZE;
            phase_nxt      = bsr_pkg::PH_IDLE;
          end else if (off_c < bsr_pkg::HEADER_BYTES) begin
            res_vld        = 1'b1;
            res.kind       = bsr_pkg::KIND_ERROR;
            res.error_code = bsr_pkg::ERR_OFFSET;
            phase_nxt      = bsr_pkg::PH_IDLE;
          end else begin
            phase_nxt = (off_c <= cnt_inc) ? bsr_pkg::PH_PIXELS : bsr_pkg::PH_SKIP;
          end
        end
      end

      bsr_pkg::PH_SKIP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= off_c) begin
          phase_nxt = bsr_pkg::PH_PIXELS;
        end
      end

      bsr_pkg::PH_PIXELS: begin
        if (bip_c == 2'd0) begin
          blue_nxt = byte_value;
          bip_nxt  = 2'd1;
        end else if (bip_c == 2'd1) begin
          green_nxt = byte_value;
          bip_nxt   = 2'd2;
        end else begin
          // Red byte closes the pixel
          res_vld        = 1'b1;
          res.kind       = bsr_pkg::KIND_PIXEL;
          res.pixel_565  = {byte_value[7:3], green_c[7:2], blue_c[7:3]};
          res.screen_x   = bsr_pkg::DIM_W'(origin_x) + col_c;
          res.screen_y   = bsr_pkg::DIM_W'(origin_y) + hgt_c - bsr_pkg::DIM_W'(1) - row_c;
          res.error_code = bsr_pkg::ERR_MAGIC;
          res.last_pixel = last_img;
          bip_nxt        = 2'd0;
          if (last_img) begin
            phase_nxt = bsr_pkg::PH_IDLE;
          end else if (last_col) begin
            col_nxt = '0;
            row_nxt = row_inc[bsr_pkg::DIM_W-1:0];
          end else begin
            col_nxt = col_inc[bsr_pkg::DIM_W-1:0];
          end
        end
      end

      bsr_pkg::PH_IDLE: begin
        // Drop bytes until the next file start
      end

      default: begin
      end
    endcase
  end

  // Parse state, advanced once per byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bsr_pkg::PH_HEADER;
      cnt_r   <= '0;
      shift_r <= '0;
      off_r   <= '0;
      wid_r   <= '0;
      hgt_r   <= '0;
      blue_r  <= '0;
      green_r <= '0;
      bip_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      off_r   <= off_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      bip_r   <= bip_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

### rtl/core/bsr_out_stage.sv
// Result register: holds one result beat until the receiver takes it.
module bsr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             res_vld,
  input  bsr_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output bsr_pkg::result_t out_res
);

  logic             vld_r;
  bsr_pkg::result_t res_r;

  assign free      = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  // Valid bit: refill or drain whenever the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= advance && res_vld;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      res_r <= res;
    end
  end

endmodule
